### sv/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  `ASSERT_PROP(lbl, clk, rst_n, !(expr))

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### sv/srt_pkg.sv
`default_nettype none

package srt_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned AddrW    = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayloadW = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned EntryCntW = 7;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DELETED   = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_WALK,
    S_INS_PLACE,
    S_DEL_FIND,
    S_DEL_SHIFT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic signed [KeyW-1:0] key;
    logic [PayloadW-1:0]    payload;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

### sv/srt_req_if.sv
`default_nettype none

interface srt_req_if
  import srt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic                   func;
  logic signed [KeyW-1:0] key;
  logic [PayloadW-1:0]    payload;

  modport source (output valid, func, key, payload, input ready);
  modport sink (input valid, func, key, payload, output ready);
endinterface

`default_nettype wire

### sv/srt_rsp_if.sv
`default_nettype none

interface srt_rsp_if
  import srt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [EntryCntW-1:0] entry_count;

  modport source (output valid, status, entry_count, input ready);
  modport sink (input valid, status, entry_count, output ready);
endinterface

`default_nettype wire

### sv/srt_mem.sv
`default_nettype none

module srt_mem
  import srt_pkg::*;
(
  input  wire logic     clk_i,
  input  wire mem_req_t req_i,
  output entry_t        rdata_o
);

  entry_t mem_q [Capacity];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // one registered read port, read every cycle
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### sv/sorted_record_table.sv
// Sorted record table: up to 64 records (signed 32-bit key, 32-bit payload) kept in ascending
// key order in a memory with one write port and one registered read port. An insert walks
// down from the last record, moving each record with a key greater than or equal to the new
// one up a slot, and drops the new record into the gap. A delete scans up from the first
// record for a key match and then moves every later record down a slot. Both walks go one
// memory entry per cycle. Full-table inserts and empty-table deletes go straight to the
// response. The last busy cycle loads the response register, which shows the result from the
// next cycle on; while that register still holds an unaccepted response the block waits in
// that last cycle. The request side is ready only while no operation is in progress.
`default_nettype none

`include "assert_macros.svh"

module sorted_record_table
  import srt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  srt_req_if.sink    req_i,
  srt_rsp_if.source  rsp_o
);

  state_e                 state_q, state_d;
  logic [CountW-1:0]      idx_q, idx_d;
  logic [CountW-1:0]      count_q, count_d;
  status_e                stat_q, stat_d;
  logic signed [KeyW-1:0] key_q;
  logic [PayloadW-1:0]    payload_q;
  logic                   rsp_valid_q, rsp_valid_d;
  status_e                rsp_status_q;
  logic [EntryCntW-1:0]   rsp_count_q;

  mem_req_t mem_req;
  entry_t   rdata;
  logic     accept;
  logic     rsp_load;
  logic     move_up;

  srt_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  assign accept  = req_i.valid && req_i.ready;
  // the one compare unit used by the insert walk
  assign move_up = (rdata.key >= key_q);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    count_d       = count_q;
    stat_d        = stat_q;
    rsp_load      = 1'b0;
    req_i.ready   = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = idx_q[AddrW-1:0];
    mem_req.wdata = '{key: key_q, payload: payload_q};
    mem_req.raddr = AddrW'(idx_q + CountW'(1));

    case (state_q)
      S_IDLE: begin
        req_i.ready   = 1'b1;
        // prefetch the first entry that the walk will look at
        mem_req.raddr = (req_i.func == FUNC_DELETE) ? '0 : AddrW'(count_q - CountW'(1));
        if (accept) begin
          if (req_i.func == FUNC_INSERT) begin
            if (count_q == CountW'(Capacity)) begin
              stat_d  = STAT_FULL;
              state_d = S_RESP;
            end else if (count_q == '0) begin
              idx_d   = '0;
              state_d = S_INS_PLACE;
            end else begin
              idx_d   = count_q;
              state_d = S_INS_WALK;
            end
          end else begin
            if (count_q == '0) begin
              stat_d  = STAT_EMPTY;
              state_d = S_RESP;
            end else begin
              idx_d   = '0;
              state_d = S_DEL_FIND;
            end
          end
        end
      end

      S_INS_WALK: begin
        // rdata holds entry idx-1, slot idx is free
        mem_req.raddr = AddrW'(idx_q - CountW'(2));
        mem_req.we    = 1'b1;
        if (move_up) begin
          mem_req.wdata = rdata;
          idx_d         = idx_q - CountW'(1);
          if (idx_q == CountW'(1)) begin
            state_d = S_INS_PLACE;
          end
        end else begin
          stat_d  = STAT_INSERTED;
          state_d = S_RESP;
        end
      end

      S_INS_PLACE: begin
        mem_req.we = 1'b1;
        stat_d     = STAT_INSERTED;
        state_d    = S_RESP;
      end

      S_DEL_FIND: begin
        // rdata holds entry idx
        if (rdata.key == key_q) begin
          state_d = S_DEL_SHIFT;
        end else if (idx_q + CountW'(1) == count_q) begin
          stat_d  = STAT_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          idx_d = idx_q + CountW'(1);
        end
      end

      S_DEL_SHIFT: begin
        // rdata holds entry idx+1, moved down into slot idx while idx is not the last entry
        mem_req.raddr = AddrW'(idx_q + CountW'(2));
        if (idx_q + CountW'(1) == count_q) begin
          stat_d  = STAT_DELETED;
          state_d = S_RESP;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = rdata;
          idx_d         = idx_q + CountW'(1);
        end
      end

      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
          if (stat_q == STAT_INSERTED) begin
            count_d = count_q + CountW'(1);
          end else if (stat_q == STAT_DELETED) begin
            count_d = count_q - CountW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    stat_q <= stat_d;
    if (accept) begin
      key_q     <= req_i.key;
      payload_q <= req_i.payload;
    end
    if (rsp_load) begin
      rsp_status_q <= stat_q;
      rsp_count_q  <= EntryCntW'(count_d);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.entry_count = rsp_count_q;

  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CountW'(Capacity))
  `ASSERT_PROP(a_count_step, clk_i, rst_ni,
    (count_q != $past(count_q)) |->
      (count_q == $past(count_q) + CountW'(1) || count_q == $past(count_q) - CountW'(1)))
  `ASSERT_PROP(a_full_only_when_full, clk_i, rst_ni,
    (rsp_load && stat_q == STAT_FULL) |-> (count_q == CountW'(Capacity)))
  `ASSERT_PROP(a_no_walk_on_empty, clk_i, rst_ni,
    (state_q == S_DEL_FIND || state_q == S_DEL_SHIFT || state_q == S_INS_WALK)
      |-> (count_q != '0))

endmodule

`default_nettype wire

### tb/sorted_record_table_tb.sv
`timescale 1ns / 1ps

module sorted_record_table_tb
  import srt_pkg::*;
();

  typedef struct packed {
    status_e              status;
    logic [EntryCntW-1:0] entry_count;
  } table_reply_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN,
    STALL_HOLD
  } stall_mode_e;

  localparam logic signed [KeyW-1:0] KeyMin = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] KeyMax = {1'b0, {(KeyW-1){1'b1}}};
  localparam int unsigned DrainCycles = 100;

  logic clk = 1'b0;
  logic rst_n;

  srt_req_if req_if ();
  srt_rsp_if rsp_if ();

  sorted_record_table dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the table, ascending key order
  logic signed [KeyW-1:0] held_keys[$];
  logic [PayloadW-1:0]    held_payloads[$];
  table_reply_t           pending_replies[$];

  int unsigned mismatch_cnt = 0;
  int unsigned reply_cnt    = 0;
  int unsigned status_tally[5];
  int          burst_left   = 1;

  stall_mode_e stall_mode      = STALL_NONE;
  int          stall_left      = 0;
  logic [31:0] stall_pattern   = '0;
  logic [4:0]  stall_phase     = '0;

  function automatic table_reply_t predict_table_op(func_e op, logic signed [KeyW-1:0] k,
                                                    logic [PayloadW-1:0] p);
    table_reply_t r;
    int pos;
    pos = 0;
    if (op == FUNC_INSERT) begin
      if (held_keys.size() >= Capacity) begin
        r.status = STAT_FULL;
      end else begin
        // new record goes ahead of any equal key
        while (pos < held_keys.size() && held_keys[pos] < k) pos++;
        held_keys.insert(pos, k);
        held_payloads.insert(pos, p);
        r.status = STAT_INSERTED;
      end
    end else if (held_keys.size() == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      while (pos < held_keys.size() && held_keys[pos] != k) pos++;
      if (pos == held_keys.size()) begin
        r.status = STAT_NOT_FOUND;
      end else begin
        held_keys.delete(pos);
        held_payloads.delete(pos);
        r.status = STAT_DELETED;
      end
    end
    r.entry_count = EntryCntW'(held_keys.size());
    return r;
  endfunction

  function automatic logic signed [KeyW-1:0] pick_key();
    int small_key;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        // narrow range so duplicates and hits are common
        small_key = int'($urandom_range(0, 16)) - 8;
        return KeyW'(small_key);
      end
      4: return KeyMin + KeyW'($urandom_range(0, 3));
      5: return KeyMax - KeyW'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [KeyW-1:0] pick_delete_key(int hit_pct);
    if (held_keys.size() != 0 && $urandom_range(0, 99) < hit_pct)
      return held_keys[$urandom_range(0, held_keys.size() - 1)];
    return pick_key();
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch at %0t: %s", $time, what);
  endtask

  // drive one command and hold it until the block takes it
  task automatic send_record(func_e op, logic signed [KeyW-1:0] k, logic [PayloadW-1:0] p);
    table_reply_t r;
    int gap;
    req_if.valid   <= 1'b1;
    req_if.func    <= op;
    req_if.key     <= k;
    req_if.payload <= p;
    do @(posedge clk); while (!req_if.ready);
    r = predict_table_op(op, k, p);
    pending_replies.push_back(r);
    status_tally[int'(r.status)]++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        9:          gap = $urandom_range(10, 80);
        default:    gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic test_directed_corners();
    send_record(FUNC_DELETE, 32'sd5, '0);
    send_record(FUNC_INSERT, KeyMax, '1);
    send_record(FUNC_INSERT, KeyMin, '0);
    send_record(FUNC_INSERT, 32'sd0, 32'h3f80_0000);
    send_record(FUNC_INSERT, -32'sd1, 32'h8000_0000);
    send_record(FUNC_INSERT, 32'sd0, 32'h7fff_ffff);
    send_record(FUNC_INSERT, 32'sd1, 32'h5555_aaaa);
    send_record(FUNC_INSERT, KeyMax, 32'haaaa_5555);
    send_record(FUNC_DELETE, 32'sd0, '1);
    send_record(FUNC_DELETE, 32'sd0, '0);
    send_record(FUNC_DELETE, 32'sd0, '0);
    send_record(FUNC_DELETE, 32'sd12345, '0);
    send_record(FUNC_DELETE, KeyMin, '0);
    send_record(FUNC_DELETE, KeyMax, '0);
    send_record(FUNC_DELETE, -32'sd1, '0);
    send_record(FUNC_DELETE, KeyMax, '0);
    send_record(FUNC_DELETE, 32'sd1, '0);
    send_record(FUNC_DELETE, KeyMax, '0);
  endtask

  task automatic test_fill_past_full();
    while (held_keys.size() < Capacity) send_record(FUNC_INSERT, pick_key(), $urandom);
    repeat (4) send_record(FUNC_INSERT, pick_key(), $urandom);
    // free one slot at the boundary, refill it, then overflow again
    send_record(FUNC_DELETE, pick_delete_key(100), $urandom);
    send_record(FUNC_INSERT, pick_key(), $urandom);
    send_record(FUNC_INSERT, KeyMin, $urandom);
    send_record(FUNC_INSERT, KeyMax, $urandom);
  endtask

  task automatic test_drain_to_empty();
    while (held_keys.size() != 0) send_record(FUNC_DELETE, pick_delete_key(90), $urandom);
    repeat (2) send_record(FUNC_DELETE, pick_key(), $urandom);
  endtask

  task automatic test_random_churn(int unsigned n_cmds);
    int insert_pct;
    insert_pct = 50;
    for (int unsigned i = 0; i < n_cmds; i++) begin
      // shift the insert/delete mix so the table swings between empty and full
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       insert_pct = 25;
          1:       insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      if ($urandom_range(0, 99) < insert_pct)
        send_record(FUNC_INSERT, pick_key(), $urandom);
      else
        send_record(FUNC_DELETE, pick_delete_key(75), $urandom);
    end
  endtask

  // reply checker and receiver stall generator
  always @(posedge clk) begin
    table_reply_t want;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      reply_cnt++;
      if (pending_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected reply, status %0d count %0d",
                                rsp_if.status, rsp_if.entry_count));
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.status !== want.status)
          flag_mismatch($sformatf("status expected %0d, actual %0d",
                                  want.status, rsp_if.status));
        if (rsp_if.entry_count !== want.entry_count)
          flag_mismatch($sformatf("entry_count expected %0d, actual %0d",
                                  want.entry_count, rsp_if.entry_count));
      end
    end

    if (stall_left <= 0) begin
      stall_mode    = stall_mode_e'($urandom_range(0, 3));
      stall_pattern = $urandom;
      stall_left    = (stall_mode == STALL_HOLD) ? $urandom_range(5, 40)
                                                 : $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    stall_phase = stall_phase + 5'd1;
    case (stall_mode)
      STALL_NONE:    rsp_if.ready <= 1'b1;
      STALL_RANDOM:  rsp_if.ready <= ($urandom_range(0, 9) > 2);
      STALL_PATTERN: rsp_if.ready <= stall_pattern[stall_phase];
      default:       rsp_if.ready <= 1'b0;
    endcase
  end

  initial begin
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_INSERT;
    req_if.key     = '0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_fill_past_full();
    test_drain_to_empty();
    test_random_churn(700);

    req_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("checked %0d replies: %0d inserts, %0d deletes, %0d inserts refused as full",
             reply_cnt, status_tally[int'(STAT_INSERTED)], status_tally[int'(STAT_DELETED)],
             status_tally[int'(STAT_FULL)]);
    $display("%0d deletes on an empty table, %0d deletes of absent keys, %0d mismatches",
             status_tally[int'(STAT_EMPTY)], status_tally[int'(STAT_NOT_FOUND)], mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("run timed out");
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/srt_pkg.sv
sv/srt_req_if.sv
sv/srt_rsp_if.sv
sv/srt_mem.sv
sv/sorted_record_table.sv
tb/sorted_record_table_tb.sv
